### hw/rtl/mps_pkg.sv
// ---------------------------------------------------------------------------
// mps_pkg
// Types and constants shared by the program command sequencer modules.
// ---------------------------------------------------------------------------
package mps_pkg;

	typedef enum logic [1:0] {
		REQ_CTRL_RD = 2'd0,
		REQ_CTRL_WR = 2'd1,
		REQ_CMD_WR  = 2'd2,
		REQ_CMD_RD  = 2'd3
	} req_t;

	localparam logic [7:0]  OFF_TARGET = 8'h30;
	localparam logic [7:0]  OFF_STATUS = 8'h80;
	localparam logic [7:0]  OFF_ENTRY  = 8'h84;
	localparam int          ENTRY_BIT  = 7;
	localparam logic [31:0] READY_VAL  = 32'h0000_8000;

	localparam logic [7:0]  CMD_OPEN1  = 8'h40;
	localparam logic [7:0]  CMD_OPEN2  = 8'h08;
	localparam logic [7:0]  CMD_COMMIT = 8'hD0;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // take the word on the input port
		logic load_read;   // load read response into the output register
		logic payload_rd;  // fetch payload entry at the emit index
		logic load_emit;   // load program write into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_read;     // current input word gives a read response
		logic commit;      // current input word commits a collection
		logic count_zero;  // nothing collected
		logic last_emit;   // emit index is at the final stored halfword
		logic out_free;    // output register can take a result this cycle
	} status_t;

endpackage

### hw/rtl/mps_ctrl.sv
// ---------------------------------------------------------------------------
// mps_ctrl
// Sequencer state machine: accepts input words, waits for memory reads and
// steps through the stored halfwords on a commit.
// ---------------------------------------------------------------------------
module mps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output mps_pkg::cmd_t    cmd,
	input  mps_pkg::status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.accept     = in_valid;
			ST_READ:  cmd.load_read  = status.out_free;
			ST_FETCH: cmd.payload_rd = 1'b1;
			ST_EMIT:  cmd.load_emit  = status.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (status.is_read) begin
							state_q <= ST_READ;
							ready_q <= 1'b0;
						end else if (status.commit && !status.count_zero) begin
							state_q <= ST_FETCH;
							ready_q <= 1'b0;
						end
					end
				end
				ST_READ: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free) begin
						if (status.last_emit) begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

### hw/rtl/mps_datapath.sv
// ---------------------------------------------------------------------------
// mps_datapath
// Register shadow, target and mode registers, command phase tracking,
// payload store and the output register.
// ---------------------------------------------------------------------------
module mps_datapath #(
	parameter int SHADOW_WORDS  = 64,
	parameter int PAYLOAD_BYTES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        req_type,
	input  logic [7:0]        offset,
	input  logic              halfword_access,
	input  logic [31:0]       write_data,
	input  mps_pkg::cmd_t     cmd,
	output mps_pkg::status_t  status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              resp_kind,
	output logic [31:0]       read_data,
	output logic [31:0]       mem_address,
	output logic [15:0]       mem_halfword,
	output logic              last
);

	localparam int HALVES = PAYLOAD_BYTES / 2;
	localparam int SAW    = $clog2(SHADOW_WORDS);
	localparam int PIW    = (HALVES > 1) ? $clog2(HALVES) : 1;
	localparam int PCW    = $clog2(HALVES + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_OPEN1,
		PH_COLLECT
	} phase_t;

	typedef enum logic [1:0] {
		RS_MEM,
		RS_ENTRY,
		RS_STATUS,
		RS_ZERO
	} rsel_t;

	// register shadow
	logic [31:0]           shd_mem [SHADOW_WORDS];
	logic [SHADOW_WORDS-1:0] shd_vld_q;
	logic [31:0]           shd_rdata_q;
	logic                  rd_vld_q;

	// payload store, no reset: only entries written since the opener are read
	logic [15:0]           pl_mem [HALVES];
	logic [15:0]           pl_rdata_q;

	logic [31:0]           target_q;
	logic                  mode_q;
	phase_t                phase_q;
	logic [PCW-1:0]        count_q;
	logic [PIW-1:0]        idx_q;
	rsel_t                 rsel_q;

	logic                  out_valid_q;
	logic                  resp_kind_q;
	logic [31:0]           read_data_q;
	logic [31:0]           mem_address_q;
	logic [15:0]           mem_halfword_q;
	logic                  last_q;

	logic [5:0]            word_idx;
	logic                  idx_ok;
	logic [SAW-1:0]        shd_idx;
	logic [7:0]            cmd_byte;
	logic                  ctrl_rd, ctrl_wr, cmd_wr, cmd_rd;
	logic                  byte_wr, half_wr, commit;
	logic                  shd_we, pl_we;
	logic                  out_free;
	logic [31:0]           rd_value;

	assign word_idx = offset[7:2];
	assign idx_ok   = int'(word_idx) < SHADOW_WORDS;
	assign shd_idx  = SAW'(word_idx);
	assign cmd_byte = write_data[7:0];

	assign ctrl_rd  = req_type == mps_pkg::REQ_CTRL_RD;
	assign ctrl_wr  = req_type == mps_pkg::REQ_CTRL_WR;
	assign cmd_wr   = req_type == mps_pkg::REQ_CMD_WR;
	assign cmd_rd   = req_type == mps_pkg::REQ_CMD_RD;
	assign byte_wr  = cmd_wr && !halfword_access;
	assign half_wr  = cmd_wr && halfword_access;
	assign commit   = byte_wr && (cmd_byte == mps_pkg::CMD_COMMIT) && (phase_q == PH_COLLECT);

	assign shd_we   = cmd.accept && ctrl_wr && idx_ok;
	assign pl_we    = cmd.accept && half_wr && (phase_q == PH_COLLECT)
		&& (count_q < PCW'(HALVES));

	assign out_free = !out_valid_q || out_ready;

	assign status.is_read    = ctrl_rd || cmd_rd;
	assign status.commit     = commit;
	assign status.count_zero = count_q == '0;
	assign status.last_emit  = (PCW'(idx_q) + PCW'(1)) == count_q;
	assign status.out_free   = out_free;

	always_comb begin
		case (rsel_q)
			RS_MEM:    rd_value = rd_vld_q ? shd_rdata_q : '0;
			RS_ENTRY:  rd_value = 32'(mode_q) << mps_pkg::ENTRY_BIT;
			RS_STATUS: rd_value = mps_pkg::READY_VAL;
			default:   rd_value = '0;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (shd_we)
			shd_mem[shd_idx] <= write_data;
		if (cmd.accept && ctrl_rd)
			shd_rdata_q <= shd_mem[shd_idx];
		if (pl_we)
			pl_mem[count_q[PIW-1:0]] <= write_data[15:0];
		if (cmd.payload_rd)
			pl_rdata_q <= pl_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shd_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			target_q  <= '0;
			mode_q    <= 1'b0;
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rsel_q    <= RS_ZERO;
		end else begin
			if (shd_we)
				shd_vld_q[shd_idx] <= 1'b1;
			if (cmd.accept) begin
				if (ctrl_rd) begin
					rd_vld_q <= shd_vld_q[shd_idx];
					if (offset == mps_pkg::OFF_ENTRY)
						rsel_q <= RS_ENTRY;
					else if (offset == mps_pkg::OFF_STATUS)
						rsel_q <= RS_STATUS;
					else if (idx_ok)
						rsel_q <= RS_MEM;
					else
						rsel_q <= RS_ZERO;
				end
				if (cmd_rd)
					rsel_q <= RS_ZERO;
				if (ctrl_wr) begin
					if (offset == mps_pkg::OFF_ENTRY)
						mode_q <= write_data[mps_pkg::ENTRY_BIT];
					if (offset == mps_pkg::OFF_TARGET)
						target_q <= write_data;
				end
				if (pl_we)
					count_q <= count_q + PCW'(1);
				if (byte_wr) begin
					if (cmd_byte == mps_pkg::CMD_OPEN1) begin
						phase_q <= PH_OPEN1;
					end else if (cmd_byte == mps_pkg::CMD_OPEN2 && phase_q == PH_OPEN1) begin
						phase_q <= PH_COLLECT;
						count_q <= '0;
					end else begin
						phase_q <= PH_IDLE;
						if (commit)
							idx_q <= '0;
					end
				end
			end
			if (cmd.load_emit && !status.last_emit)
				idx_q <= idx_q + PIW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_read || cmd.load_emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_read) begin
			resp_kind_q    <= 1'b0;
			read_data_q    <= rd_value;
			mem_address_q  <= '0;
			mem_halfword_q <= '0;
			last_q         <= 1'b1;
		end else if (cmd.load_emit) begin
			resp_kind_q    <= 1'b1;
			read_data_q    <= '0;
			mem_address_q  <= target_q + 32'({idx_q, 1'b0});
			mem_halfword_q <= pl_rdata_q;
			last_q         <= status.last_emit;
		end
	end

	assign out_valid    = out_valid_q;
	assign resp_kind    = resp_kind_q;
	assign read_data    = read_data_q;
	assign mem_address  = mem_address_q;
	assign mem_halfword = mem_halfword_q;
	assign last         = last_q;

endmodule

### hw/rtl/mram_program_command_sequencer.sv
// ---------------------------------------------------------------------------
// mram_program_command_sequencer
// Controller register window with shadow, plus a command port that collects
// halfwords and emits memory program writes on commit.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | req_type, offset, halfword_access, write_data
//  out     | out_valid / out_ready| resp_kind, read_data, mem_address,
//          |                      | mem_halfword, last
//
// For a read, the shadow read is registered before the output register
// loads. A commit emits each stored halfword in turn, one payload read
// and then one output load per halfword.
// Reset clears shadow valid bits at once; no clearing pass is needed.
// A stalled output holds the sequencer in its read or emit step; writes are
// still taken while an earlier result waits.
// ---------------------------------------------------------------------------
module mram_program_command_sequencer #(
	parameter int SHADOW_WORDS  = 64,
	parameter int PAYLOAD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  offset,
	input  logic        halfword_access,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        resp_kind,
	output logic [31:0] read_data,
	output logic [31:0] mem_address,
	output logic [15:0] mem_halfword,
	output logic        last
);

	mps_pkg::cmd_t    cmd;
	mps_pkg::status_t status;

	mps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	mps_datapath #(
		.SHADOW_WORDS  (SHADOW_WORDS),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_type        (req_type),
		.offset          (offset),
		.halfword_access (halfword_access),
		.write_data      (write_data),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.resp_kind       (resp_kind),
		.read_data       (read_data),
		.mem_address     (mem_address),
		.mem_halfword    (mem_halfword),
		.last            (last)
	);

endmodule

### hw/rtl/mps_checker.sv
// ---------------------------------------------------------------------------
// mps_checker
// Port-level checks for the program command sequencer, bound to the top.
// ---------------------------------------------------------------------------
module mps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic        resp_kind,
	input logic [31:0] read_data,
	input logic [31:0] mem_address,
	input logic [15:0] mem_halfword,
	input logic        last
);

	// inside a program run: address the next word must carry
	logic        run_q;
	logic [31:0] next_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			next_addr_q <= '0;
		end else if (out_valid && out_ready && resp_kind) begin
			run_q       <= !last;
			next_addr_q <= mem_address + 32'd2;
		end
	end

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(mem_address) && $stable(mem_halfword) && $stable(last))
		else $error("output word changed while stalled");

	// a read response is always a single, final word with no program fields
	a_read_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !resp_kind |-> last && mem_address == 32'd0 && mem_halfword == 16'd0)
		else $error("malformed read response");

	a_prog_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && resp_kind |-> read_data == 32'd0)
		else $error("program write carries read data");

	// a read blocks further input until its response is formed
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == mps_pkg::REQ_CTRL_RD
			|| req_type == mps_pkg::REQ_CMD_RD) |=> !in_ready)
		else $error("input taken during read");

	// program writes of one run step by two bytes
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_q |-> resp_kind && mem_address == next_addr_q)
		else $error("program write address out of step");

endmodule

bind mram_program_command_sequencer mps_checker u_mps_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for mram_program_command_sequencer. A directed table
// covers the status and entry registers, the target latch, program command
// sequences and the error paths of the command port. Random traffic follows,
// mostly well-formed program sequences with noise mixed in. Every result is
// checked field by field against an in-bench model or the row's read data.
// ---------------------------------------------------------------------------
module tb;

	localparam int PAYLOAD_HALVES = 16;
	localparam int RANDOM_WORDS   = 135;
	localparam int NDIR           = 25;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_OPEN1   = 2'd1,
		PH_COLLECT = 2'd2
	} cmd_phase_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] rdata;
		logic [31:0] addr;
		logic [15:0] hword;
		logic        last;
	} resp_s;

	typedef struct packed {
		mps_pkg::req_t req;
		logic [7:0]    off;
		logic          half;
		logic [31:0]   data;
		logic          typed;  // expected read data given in the row
		logic [31:0]   rdata;
	} row_s;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type        = mps_pkg::REQ_CTRL_RD;
	logic [7:0]  offset          = 8'h00;
	logic        halfword_access = 1'b0;
	logic [31:0] write_data      = 32'h0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic        resp_kind;
	logic [31:0] read_data;
	logic [31:0] mem_address;
	logic [15:0] mem_halfword;
	logic        last;

	// sequencer model state
	logic [31:0] shadow [0:63];
	logic [31:0] target_addr;
	logic [15:0] pay_store [0:PAYLOAD_HALVES-1];
	int          pay_count;
	cmd_phase_t  phase;
	logic        pmode;

	resp_s due_resp [$];
	row_s  dir_rows [0:NDIR-1];

	int burst_left    = 0;
	int words_counted = 0;
	int mismatches    = 0;
	int n_reads       = 0;
	int n_prog        = 0;
	int n_commits     = 0;
	bit hold_pending  = 1'b0;

	mram_program_command_sequencer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.offset          (offset),
		.halfword_access (halfword_access),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.resp_kind       (resp_kind),
		.read_data       (read_data),
		.mem_address     (mem_address),
		.mem_halfword    (mem_halfword),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// Update the model with one accepted word and queue the results it causes.
	task automatic sequencer_access(input mps_pkg::req_t req, input logic [7:0] off,
			input logic hw, input logic [31:0] data);
		logic [31:0] rd;
		logic [7:0]  b;
		case (req)
			mps_pkg::REQ_CTRL_RD: begin
				if (off == mps_pkg::OFF_ENTRY)
					rd = 32'(pmode) << mps_pkg::ENTRY_BIT;
				else if (off == mps_pkg::OFF_STATUS)
					rd = mps_pkg::READY_VAL;
				else
					rd = shadow[off[7:2]];  // 8-bit offset never leaves the shadow
				due_resp.push_back('{1'b0, rd, 32'h0, 16'h0, 1'b1});
			end
			mps_pkg::REQ_CTRL_WR: begin
				if (off == mps_pkg::OFF_ENTRY)
					pmode = data[mps_pkg::ENTRY_BIT];
				if (off == mps_pkg::OFF_TARGET)
					target_addr = data;
				shadow[off[7:2]] = data;
			end
			mps_pkg::REQ_CMD_WR: begin
				b = data[7:0];
				if (hw) begin
					if (phase == PH_COLLECT && pay_count < PAYLOAD_HALVES) begin
						pay_store[pay_count] = data[15:0];
						pay_count++;
					end
				end else if (b == mps_pkg::CMD_OPEN1) begin
					phase = PH_OPEN1;
				end else if (b == mps_pkg::CMD_OPEN2 && phase == PH_OPEN1) begin
					phase = PH_COLLECT;
					pay_count = 0;
				end else if (b == mps_pkg::CMD_COMMIT && phase == PH_COLLECT) begin
					n_commits++;
					for (int i = 0; i < pay_count; i++)
						due_resp.push_back('{1'b1, 32'h0, target_addr + 32'(2 * i),
							pay_store[i], i + 1 == pay_count});
					phase = PH_IDLE;
				end else begin
					phase = PH_IDLE;
				end
			end
			default: begin
				due_resp.push_back('{1'b0, 32'h0, 32'h0, 16'h0, 1'b1});
			end
		endcase
	endtask

	// Offer one word, in bursts with random gaps, and hand it to the model once taken.
	task automatic send_word(input mps_pkg::req_t req, input logic [7:0] off, input logic hw,
			input logic [31:0] data, input logic typed = 1'b0,
			input logic [31:0] rdata = 32'h0);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
		end
		in_valid        <= 1'b1;
		req_type        <= req;
		offset          <= off;
		halfword_access <= hw;
		write_data      <= data;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		words_counted++;
		if (typed)
			due_resp.push_back('{1'b0, rdata, 32'h0, 16'h0, 1'b1});
		else
			sequencer_access(req, off, hw, data);
	endtask

	task automatic send_cmd_byte(input logic [7:0] b);
		logic [31:0] w;
		w = $urandom;
		w[7:0] = b;
		send_word(mps_pkg::REQ_CMD_WR, 8'($urandom_range(0, 255)), 1'b0, w);
	endtask

	function automatic logic [7:0] pick_cmd_byte();
		case ($urandom_range(0, 3))
			0: return mps_pkg::CMD_OPEN1;
			1: return mps_pkg::CMD_OPEN2;
			2: return mps_pkg::CMD_COMMIT;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic report(input string what, input resp_s want, input resp_s got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: exp kind=%0d rd=%h addr=%h hw=%h last=%0d",
				what, want.kind, want.rdata, want.addr, want.hword, want.last);
			$display("  got kind=%0d rd=%h addr=%h hw=%h last=%0d",
				got.kind, got.rdata, got.addr, got.hword, got.last);
		end
	endtask

	// result checker
	initial begin
		resp_s got;
		resp_s want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = '{resp_kind, read_data, mem_address, mem_halfword, last};
				if (due_resp.size() == 0) begin
					report("no result was due", '0, got);
				end else begin
					want = due_resp.pop_front();
					if (got !== want)
						report("result mismatch", want, got);
					if (want.kind)
						n_prog++;
					else
						n_reads++;
				end
			end
		end
	end

	// receiver: switches between random stall patterns, plus one long hold-off
	initial begin
		int mode;
		int hold_left;
		int cyc;
		mode = 0;
		hold_left = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_pending) begin
				hold_left = 250;
				hold_pending = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					2: out_ready <= (cyc % 4 != 3);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int start_count;
		int episode;
		int r;
		int r2;
		int n;
		dir_rows = '{
			'{mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_STATUS, 1'b0, 32'h0, 1'b1,
				mps_pkg::READY_VAL},
			'{mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_ENTRY,  1'b0, 32'h0,         1'b1, 32'h0},
			'{mps_pkg::REQ_CTRL_RD, 8'hFF,               1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0},
			'{mps_pkg::REQ_CMD_RD,  8'hFF,               1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0},
			'{mps_pkg::REQ_CTRL_WR, mps_pkg::OFF_ENTRY,  1'b0, 32'h0000_0080, 1'b0, 32'h0},
			'{mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_ENTRY,  1'b0, 32'h0, 1'b1, 32'h0000_0080},
			// target near the top so the emitted addresses wrap
			'{mps_pkg::REQ_CTRL_WR, mps_pkg::OFF_TARGET, 1'b0, 32'hFFFF_FFFC, 1'b0, 32'h0},
			'{mps_pkg::REQ_CTRL_RD, 8'h31,               1'b0, 32'h0,         1'b0, 32'h0},
			'{mps_pkg::REQ_CTRL_WR, mps_pkg::OFF_STATUS, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0},
			'{mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_STATUS, 1'b0, 32'h0, 1'b1,
				mps_pkg::READY_VAL},
			'{mps_pkg::REQ_CTRL_RD, 8'h82,               1'b0, 32'h0,         1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b1, 32'h0000_1234, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'hFFFF_FF40, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_0008, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b1, 32'h0000_0000, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b1, 32'h5A5A_A5C3, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_00D0, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_0008, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_00D0, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_0040, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_0008, 1'b0, 32'h0},
			'{mps_pkg::REQ_CMD_WR,  8'h00,               1'b0, 32'h0000_00D0, 1'b0, 32'h0},
			'{mps_pkg::REQ_CTRL_WR, mps_pkg::OFF_ENTRY,  1'b0, 32'hFFFF_FF7F, 1'b0, 32'h0},
			'{mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_ENTRY,  1'b0, 32'h0,         1'b1, 32'h0}
		};
		for (int i = 0; i < 64; i++)
			shadow[i] = 32'h0;
		for (int i = 0; i < PAYLOAD_HALVES; i++)
			pay_store[i] = 16'h0;
		target_addr = 32'h0;
		pay_count = 0;
		phase = PH_IDLE;
		pmode = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NDIR; i++)
			send_word(dir_rows[i].req, dir_rows[i].off, dir_rows[i].half, dir_rows[i].data,
				dir_rows[i].typed, dir_rows[i].rdata);

		hold_pending = 1'b1;
		start_count = words_counted;
		episode = 0;
		while (words_counted - start_count < RANDOM_WORDS) begin
			r = (episode == 0) ? 0 : $urandom_range(0, 99);
			episode++;
			if (r < 50) begin
				send_cmd_byte(mps_pkg::CMD_OPEN1);
				if ($urandom_range(0, 11) == 0)
					send_cmd_byte(mps_pkg::CMD_OPEN1);
				send_cmd_byte(mps_pkg::CMD_OPEN2);
				// first sequence fills the payload store while the receiver holds off
				if (episode == 1)
					n = PAYLOAD_HALVES;
				else
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
						: $urandom_range(0, 16);
				for (int k = 0; k < n; k++) begin
					r2 = $urandom_range(0, 99);
					if (r2 < 5)
						send_word(mps_pkg::REQ_CTRL_RD, 8'($urandom_range(0, 255)), 1'b0,
							$urandom);
					else if (r2 < 8)
						send_word(mps_pkg::REQ_CTRL_WR, 8'($urandom_range(0, 255)), 1'b0,
							$urandom);
					else if (r2 < 10)
						send_word(mps_pkg::REQ_CMD_RD, 8'($urandom_range(0, 255)),
							1'($urandom), $urandom);
					else if (r2 == 10)
						send_cmd_byte(pick_cmd_byte());
					send_word(mps_pkg::REQ_CMD_WR, 8'($urandom_range(0, 255)), 1'b1, $urandom);
				end
				if ($urandom_range(0, 9) == 0)
					send_cmd_byte(pick_cmd_byte());
				else
					send_cmd_byte(mps_pkg::CMD_COMMIT);
			end else if (r < 65) begin
				case ($urandom_range(0, 7))
					0, 1: send_word(mps_pkg::REQ_CTRL_WR, mps_pkg::OFF_TARGET, 1'($urandom),
						$urandom);
					2: send_word(mps_pkg::REQ_CTRL_WR, mps_pkg::OFF_ENTRY, 1'($urandom),
						$urandom);
					default: send_word(mps_pkg::REQ_CTRL_WR, 8'($urandom_range(0, 255)),
						1'($urandom), $urandom);
				endcase
			end else if (r < 85) begin
				case ($urandom_range(0, 7))
					0: send_word(mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_ENTRY, 1'($urandom),
						$urandom);
					1: send_word(mps_pkg::REQ_CTRL_RD, mps_pkg::OFF_STATUS, 1'($urandom),
						$urandom);
					default: send_word(mps_pkg::REQ_CTRL_RD, 8'($urandom_range(0, 255)),
						1'($urandom), $urandom);
				endcase
			end else if (r < 92) begin
				send_word(mps_pkg::REQ_CMD_RD, 8'($urandom_range(0, 255)), 1'($urandom),
					$urandom);
			end else if (r < 96) begin
				send_cmd_byte(pick_cmd_byte());
			end else begin
				send_word(mps_pkg::REQ_CMD_WR, 8'($urandom_range(0, 255)), 1'b1, $urandom);
			end
		end
		in_valid <= 1'b0;

		while (due_resp.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("run covered %0d words (%0d from the directed table): %0d read responses,",
			words_counted, NDIR, n_reads);
		$display("%0d program writes from %0d commits, %0d result errors",
			n_prog, n_commits, mismatches);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
